[rtl/gpat_pkg.sv]
// Package for the game port axis timer: command and register codes,
// lane control struct and position/count helper functions.
// No dependencies.
`default_nettype none

package gpat_pkg;

	localparam int COUNT_RANGE = 64;
	localparam int CntProdW    = 17 + $clog2(COUNT_RANGE + 1);

	localparam logic [31:0] TimeoutReset = 32'd10000;
	localparam logic [15:0] BaseReset    = 16'd24;
	localparam logic [15:0] SpanReset    = 16'd1320;
	localparam logic [16:0] OffCentre    = 17'd32768;
	localparam logic [16:0] OffMax       = 17'd65536;

	typedef enum logic [1:0] {
		CMD_READ    = 2'd0,
		CMD_TRIGGER = 2'd1,
		CMD_SET_POS = 2'd2,
		CMD_SET_BTN = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_TIMED_MODE  = 3'd0,
		REG_ENABLE_MASK = 3'd1,
		REG_SWAP        = 3'd2,
		REG_TIMEOUT     = 3'd3,
		REG_BASE        = 3'd4,
		REG_SPAN        = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic timed;
		logic load;
		logic read;
		logic clear;
	} gpat_lane_ctl_t;

	// saturate to -32768..32768 and offset to 0..65536
	function automatic logic [16:0] pos_to_off(input logic signed [16:0] p);
		logic signed [17:0] s;
		s = $signed({p[16], p}) + 18'sd32768;
		if (s < 18'sd0)
			return 17'd0;
		else if (s > 18'sd65536)
			return OffMax;
		else
			return s[16:0];
	endfunction

	function automatic logic [7:0] count_of(input logic [16:0] off);
		logic [CntProdW-1:0] p;
		p = CntProdW'(off) * CntProdW'(COUNT_RANGE);
		return p[15 +: 8];
	endfunction

endpackage

`default_nettype wire

[rtl/gpat_lane.sv]
// One axis lane of the game port: read counter and timed-mode deadline.
// Depends on gpat_pkg.
`default_nettype none

module gpat_lane
	import gpat_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire gpat_lane_ctl_t ctl,
	input  wire logic [16:0]    src_off,
	input  wire logic [31:0]    now_us,
	input  wire logic [15:0]    base_us,
	input  wire logic [15:0]    span_us,
	output logic                active
);

	logic [7:0]  count_q;
	logic [31:0] deadline_q;
	logic [7:0]  count_eff;
	logic        count_nz;
	logic [32:0] prod;
	logic [31:0] delay;
	logic [31:0] elapsed;
	logic        passed;

	always_comb begin
		count_eff = ctl.clear ? 8'd0 : count_q;
		count_nz  = (count_eff != 8'd0);
		prod      = 33'(span_us) * 33'(src_off);
		delay     = 32'(base_us) + 32'(prod[32:16]);
		elapsed   = now_us - deadline_q;
		passed    = (elapsed != 32'd0) && !elapsed[31];
		active    = ctl.timed ? !passed : count_nz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= 8'd0;
			deadline_q <= 32'd0;
		end else begin
			if (ctl.load && !ctl.timed)
				count_q <= count_of(src_off);
			else if (ctl.read && !ctl.timed)
				count_q <= count_eff - 8'(count_nz);
			else if (ctl.clear)
				count_q <= 8'd0;
			if (ctl.load && ctl.timed)
				deadline_q <= now_us + delay;
		end
	end

endmodule

`default_nettype wire

[rtl/game_port_axis_timer_core.sv]
// Top level of the game port axis timer: request register, state, result register.
// Depends on gpat_pkg and gpat_lane.
//
// Usage: requests enter on in_valid/in_stall with cmd, stick_sel, item_sel,
// position, pressed and now_us. A read request (cmd 0) gives one status byte
// on out_valid/out_stall; trigger, set-position and set-button give none.
// Each accepted request is held in the request register and executed from
// it; a read's byte is loaded into the result register as the read executes,
// and out_valid rises with it.
// Throughput is one request per cycle while the receiver takes results.
// If a result is still held by out_stall, non-read requests keep executing;
// a following read waits in the request register and in_stall rises.
// Reset clears the request and result valid flags and all button and lane
// state, centres the axes and loads the register defaults (count mode, sticks
// disabled, timeout 10000, base 24, span 1320). The user must write registers
// through cfg_we, cfg_index and cfg_data while no request is in flight; the block does not check.
`default_nettype none

module game_port_axis_timer_core
	import gpat_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic               stick_sel,
	input  wire logic               item_sel,
	input  wire logic signed [16:0] position,
	input  wire logic               pressed,
	input  wire logic [31:0]        now_us,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              port_byte
);

	logic        timed_q;
	logic [1:0]  enable_q;
	logic        swap_q;
	logic [31:0] timeout_q;
	logic [15:0] base_q;
	logic [15:0] span_q;

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [1:0]  slot_s1;
	logic [16:0] pos_s1;
	logic        pressed_s1;
	logic [31:0] now_s1;

	logic [16:0] off_q [4];
	logic [3:0]  button_q;
	logic        pending_q;
	logic [31:0] trig_time_q;

	logic        out_valid_q;
	logic [7:0]  byte_q;

	logic                exec;
	logic                do_read;
	logic                do_trig;
	logic                tmo;
	logic [3:0]          lane_en;
	logic [3:0]          lane_active;
	gpat_lane_ctl_t      lane_ctl [4];
	logic [16:0]         lane_src [4];
	logic [7:0]          byte_d;

	assign exec     = valid_s1 && !((cmd_s1 == CMD_READ) && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !exec;
	assign do_read  = exec && (cmd_s1 == CMD_READ);
	assign do_trig  = exec && (cmd_s1 == CMD_TRIGGER);
	assign tmo      = do_read && !timed_q && pending_q && ((now_s1 - trig_time_q) > timeout_q);
	assign lane_en  = {enable_q[1], enable_q[1], enable_q[0], enable_q[0]};

	always_comb begin
		lane_src[0] = off_q[0];
		lane_src[1] = off_q[1];
		lane_src[2] = swap_q ? off_q[3] : off_q[2];
		lane_src[3] = swap_q ? off_q[2] : off_q[3];
		for (int k = 0; k < 4; k++) begin
			lane_ctl[k].timed = timed_q;
			lane_ctl[k].load  = do_trig && lane_en[k];
			lane_ctl[k].read  = do_read && lane_en[k];
			lane_ctl[k].clear = tmo;
			byte_d[k]         = lane_en[k] ? lane_active[k] : 1'b1;
			byte_d[4 + k]     = lane_en[k] ? !button_q[k] : 1'b1;
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_lane
		gpat_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (lane_ctl[k]),
			.src_off (lane_src[k]),
			.now_us  (now_s1),
			.base_us (base_q),
			.span_us (span_q),
			.active  (lane_active[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timed_q   <= 1'b0;
			enable_q  <= 2'd0;
			swap_q    <= 1'b0;
			timeout_q <= TimeoutReset;
			base_q    <= BaseReset;
			span_q    <= SpanReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIMED_MODE:  timed_q   <= cfg_data[0];
				REG_ENABLE_MASK: enable_q  <= cfg_data[1:0];
				REG_SWAP:        swap_q    <= cfg_data[0];
				REG_TIMEOUT:     timeout_q <= cfg_data;
				REG_BASE:        base_q    <= cfg_data[15:0];
				REG_SPAN:        span_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (exec) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1     <= cmd_t'(cmd);
			slot_s1    <= {stick_sel, item_sel};
			pos_s1     <= pos_to_off(position);
			pressed_s1 <= pressed;
			now_s1     <= now_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++)
				off_q[k] <= OffCentre;
			button_q    <= 4'd0;
			pending_q   <= 1'b0;
			trig_time_q <= 32'd0;
		end else if (exec) begin
			unique case (cmd_s1)
				CMD_READ: begin
					if (tmo)
						pending_q <= 1'b0;
				end
				CMD_TRIGGER: begin
					if (!timed_q) begin
						pending_q   <= 1'b1;
						trig_time_q <= now_s1;
					end
				end
				CMD_SET_POS: off_q[slot_s1]    <= pos_s1;
				CMD_SET_BTN: button_q[slot_s1] <= pressed_s1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_read) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_read)
			byte_q <= byte_d;
	end

	assign out_valid = out_valid_q;
	assign port_byte = byte_q;

endmodule

`default_nettype wire
